### src/obs_pkg.sv
package obs_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int MASK_W       = 64;
    localparam int REQ_W        = 3;

    localparam logic [REQ_W-1:0] REQ_ADD       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INTERSECT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_UNION     = 3'd5;
    localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd6;

    localparam logic [CNT_W-1:0] NUM_ELEM_RESET = CNT_W'(MAX_ELEMENTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPACT,
        ST_UNION,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             in_range;
        logic [CNT_W-1:0] popped_index;
        logic             member_bit;
        logic [CNT_W-1:0] member_count;
        logic             empty_flag;
        logic             same_as_mask;
        logic             covers_mask;
        logic             within_mask;
    } result_t;

    // Saturate the programmed universe size at the bitmap width.
    function automatic logic [CNT_W-1:0] universe_size(input logic [CNT_W-1:0] value);
        logic [CNT_W-1:0] n;
        n = (value > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : value;
        return n;
    endfunction

    function automatic logic [MASK_W-1:0] universe_mask(input logic [CNT_W-1:0] n);
        logic [MASK_W-1:0] m;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (CNT_W'(i) < n);
        end
        return m;
    endfunction

endpackage

### src/ordered_bitmap_subset_core.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------------
// s_       | in        | s_valid / s_ready  | s_req_type, s_elem_index, s_other_mask
// m_       | out       | m_valid / m_ready  | in_range, popped_index, member_bit, counts, tests
// cfg_     | in        | cfg_wr_en          | cfg_wr_data (num_elements)
//
// Add, clear, query, a missed remove and an empty pop go from accept straight to done; a
// hit remove, a pop and intersect compact the order list (one order list entry a cycle),
// union walks the n indices (one element index a cycle); s_ready returns as the output
// register takes the item. Reset is synchronous, active low: the subset is empty and
// num_elements is 64. s_ready is high only while the sequencer is idle; one finished item
// may wait in the output register while the next one is taken, and a stalled m_ is held there.
module ordered_bitmap_subset_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [obs_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [obs_pkg::REQ_W-1:0]   s_req_type,
    input  logic [obs_pkg::IDX_W-1:0]   s_elem_index,
    input  logic [obs_pkg::MASK_W-1:0]  s_other_mask,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_in_range,
    output logic [obs_pkg::CNT_W-1:0]   m_popped_index,
    output logic                        m_member_bit,
    output logic [obs_pkg::CNT_W-1:0]   m_member_count,
    output logic                        m_empty_flag,
    output logic                        m_same_as_mask,
    output logic                        m_covers_mask,
    output logic                        m_within_mask
);

    // order list memory port
    logic                      mem_we;
    logic [obs_pkg::IDX_W-1:0] mem_waddr;
    logic [obs_pkg::IDX_W-1:0] mem_wdata;
    logic [obs_pkg::IDX_W-1:0] mem_raddr;
    logic [obs_pkg::IDX_W-1:0] mem_rdata;

    // finished item from the sequencer
    logic             res_valid;
    logic             res_ready;
    obs_pkg::result_t res_data;

    // output register
    logic             out_valid_reg, out_valid_next;
    obs_pkg::result_t out_reg, out_next;

    obs_order_mem u_order_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    obs_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_req      (s_req_type),
        .in_idx      (s_elem_index),
        .in_mask     (s_other_mask),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // take a new item when the register is empty or drains this cycle
    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_next       = res_data;
        end else if (m_ready) begin
            // drop the item once it is taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_in_range     = out_reg.in_range;
    assign m_popped_index = out_reg.popped_index;
    assign m_member_bit   = out_reg.member_bit;
    assign m_member_count = out_reg.member_count;
    assign m_empty_flag   = out_reg.empty_flag;
    assign m_same_as_mask = out_reg.same_as_mask;
    assign m_covers_mask  = out_reg.covers_mask;
    assign m_within_mask  = out_reg.within_mask;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_reg)))
        else $error("stalled result item changed");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |-> (!out_valid_reg || m_ready))
        else $error("result item overwritten before it was taken");

    a_empty_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_empty_flag == (m_member_count == '0)))
        else $error("empty flag disagrees with member count");

endmodule

### src/obs_order_mem.sv
module obs_order_mem (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [obs_pkg::IDX_W-1:0]  wr_addr,
    input  logic [obs_pkg::IDX_W-1:0]  wr_data,
    input  logic [obs_pkg::IDX_W-1:0]  rd_addr,
    output logic [obs_pkg::IDX_W-1:0]  rd_data
);

    logic [obs_pkg::IDX_W-1:0] mem [0:obs_pkg::MAX_ELEMENTS-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

### src/obs_engine.sv
module obs_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [obs_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [obs_pkg::REQ_W-1:0]   in_req,
    input  logic [obs_pkg::IDX_W-1:0]   in_idx,
    input  logic [obs_pkg::MASK_W-1:0]  in_mask,
    output logic                        res_valid,
    input  logic                        res_ready,
    output obs_pkg::result_t            res_data,
    output logic                        mem_we,
    output logic [obs_pkg::IDX_W-1:0]   mem_waddr,
    output logic [obs_pkg::IDX_W-1:0]   mem_wdata,
    output logic [obs_pkg::IDX_W-1:0]   mem_raddr,
    input  logic [obs_pkg::IDX_W-1:0]   mem_rdata
);

    obs_pkg::state_t state_reg, state_next;

    logic [obs_pkg::CNT_W-1:0]  num_elem_reg, num_elem_next;
    logic [obs_pkg::MASK_W-1:0] bits_reg, bits_next;
    logic [obs_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       pend_reg, pend_next;

    logic [obs_pkg::REQ_W-1:0]  req_reg, req_next;
    logic [obs_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [obs_pkg::MASK_W-1:0] mask_reg, mask_next;
    logic [obs_pkg::CNT_W-1:0]  n_reg, n_next;
    logic [obs_pkg::CNT_W-1:0]  popped_reg, popped_next;
    logic [obs_pkg::CNT_W-1:0]  rd_reg, rd_next;
    logic [obs_pkg::CNT_W-1:0]  wr_reg, wr_next;
    logic [obs_pkg::CNT_W-1:0]  iter_reg, iter_next;
    logic                       pend_first_reg, pend_first_next;

    logic [obs_pkg::CNT_W-1:0]  n_now;
    logic [obs_pkg::MASK_W-1:0] um_now;
    logic [obs_pkg::MASK_W-1:0] mem_bits;
    logic                       in_fire;
    logic                       in_rng_now;
    logic                       add_ok;
    logic                       rm_hit;
    logic                       rd_issue;
    logic                       drop_head;
    logic                       keep;
    logic                       compact_end;
    logic                       iter_live;
    logic                       u_add;
    logic                       res_in_range;

    assign n_now      = obs_pkg::universe_size(num_elem_reg);
    assign um_now     = obs_pkg::universe_mask(n_now);
    assign in_ready   = (state_reg == obs_pkg::ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign in_rng_now = ({1'b0, in_idx} < n_now);
    assign add_ok     = in_rng_now && !bits_reg[in_idx]
                        && (count_reg < obs_pkg::CNT_W'(obs_pkg::MAX_ELEMENTS));
    assign rm_hit     = in_rng_now && bits_reg[in_idx];

    assign rd_issue    = (rd_reg < count_reg);
    assign drop_head   = (req_reg == obs_pkg::REQ_POP) && pend_first_reg;
    assign keep        = bits_reg[mem_rdata] && !drop_head;
    assign compact_end = !pend_reg && !rd_issue;

    assign iter_live = (iter_reg < n_reg);
    assign u_add     = iter_live && mask_reg[iter_reg[obs_pkg::IDX_W-1:0]]
                       && !bits_reg[iter_reg[obs_pkg::IDX_W-1:0]]
                       && (count_reg < obs_pkg::CNT_W'(obs_pkg::MAX_ELEMENTS));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            obs_pkg::ST_IDLE: begin
                if (in_fire) begin
                    unique case (in_req)
                        obs_pkg::REQ_REMOVE:    state_next = rm_hit ? obs_pkg::ST_COMPACT
                                                                    : obs_pkg::ST_DONE;
                        obs_pkg::REQ_POP:       state_next = (count_reg != '0)
                                                             ? obs_pkg::ST_COMPACT
                                                             : obs_pkg::ST_DONE;
                        obs_pkg::REQ_INTERSECT: state_next = obs_pkg::ST_COMPACT;
                        obs_pkg::REQ_UNION:     state_next = obs_pkg::ST_UNION;
                        default:                state_next = obs_pkg::ST_DONE;
                    endcase
                end
            end
            obs_pkg::ST_COMPACT: begin
                if (compact_end) begin
                    state_next = obs_pkg::ST_DONE;
                end
            end
            obs_pkg::ST_UNION: begin
                if (!iter_live) begin
                    state_next = obs_pkg::ST_DONE;
                end
            end
            obs_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = obs_pkg::ST_IDLE;
                end
            end
            default: state_next = obs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        num_elem_next   = num_elem_reg;
        bits_next       = bits_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        mask_next       = mask_reg;
        n_next          = n_reg;
        popped_next     = popped_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        iter_next       = iter_reg;
        pend_first_next = pend_first_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[obs_pkg::IDX_W-1:0];
        mem_wdata       = in_idx;
        mem_raddr       = rd_reg[obs_pkg::IDX_W-1:0];

        unique case (state_reg)
            obs_pkg::ST_IDLE: begin
                if (cfg_wr_en) begin
                    num_elem_next = cfg_wr_data;
                    bits_next     = '0;
                    count_next    = '0;
                end else if (in_fire) begin
                    req_next    = in_req;
                    idx_next    = in_idx;
                    mask_next   = in_mask & um_now;
                    n_next      = n_now;
                    popped_next = n_now;
                    rd_next     = '0;
                    wr_next     = '0;
                    iter_next   = '0;
                    pend_next   = 1'b0;
                    unique case (in_req)
                        obs_pkg::REQ_ADD: begin
                            if (add_ok) begin
                                mem_we            = 1'b1;
                                bits_next[in_idx] = 1'b1;
                                count_next        = count_reg + 1'b1;
                            end
                        end
                        obs_pkg::REQ_REMOVE: begin
                            if (rm_hit) begin
                                bits_next[in_idx] = 1'b0;
                            end
                        end
                        obs_pkg::REQ_CLEAR: begin
                            bits_next  = '0;
                            count_next = '0;
                        end
                        obs_pkg::REQ_INTERSECT: begin
                            bits_next = bits_reg & in_mask & um_now;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            obs_pkg::ST_COMPACT: begin
                // read one entry ahead, write survivors down behind it
                pend_next       = rd_issue;
                pend_first_next = (rd_reg == '0);
                if (rd_issue) begin
                    rd_next = rd_reg + 1'b1;
                end
                if (pend_reg) begin
                    if (drop_head) begin
                        popped_next          = {1'b0, mem_rdata};
                        bits_next[mem_rdata] = 1'b0;
                    end
                    if (keep) begin
                        mem_we    = 1'b1;
                        mem_waddr = wr_reg[obs_pkg::IDX_W-1:0];
                        mem_wdata = mem_rdata;
                        wr_next   = wr_reg + 1'b1;
                    end
                end
                if (compact_end) begin
                    count_next = wr_reg;
                end
            end
            obs_pkg::ST_UNION: begin
                if (iter_live) begin
                    iter_next = iter_reg + 1'b1;
                end
                if (u_add) begin
                    mem_we     = 1'b1;
                    mem_wdata  = iter_reg[obs_pkg::IDX_W-1:0];
                    bits_next[iter_reg[obs_pkg::IDX_W-1:0]] = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            obs_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mem_bits     = bits_reg & obs_pkg::universe_mask(n_reg);
        res_in_range = ({1'b0, idx_reg} < n_reg);
        res_valid    = (state_reg == obs_pkg::ST_DONE);

        res_data.in_range     = res_in_range;
        res_data.popped_index = popped_reg;
        res_data.member_bit   = res_in_range && bits_reg[idx_reg];
        res_data.member_count = count_reg;
        res_data.empty_flag   = (count_reg == '0);
        res_data.same_as_mask = (mem_bits == mask_reg);
        res_data.covers_mask  = ((mask_reg & ~mem_bits) == '0);
        res_data.within_mask  = ((mem_bits & ~mask_reg) == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= obs_pkg::ST_IDLE;
            num_elem_reg <= obs_pkg::NUM_ELEM_RESET;
            bits_reg     <= '0;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            num_elem_reg <= num_elem_next;
            bits_reg     <= bits_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        mask_reg       <= mask_next;
        n_reg          <= n_next;
        popped_reg     <= popped_next;
        rd_reg         <= rd_next;
        wr_reg         <= wr_next;
        iter_reg       <= iter_next;
        pend_first_reg <= pend_first_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= obs_pkg::CNT_W'(obs_pkg::MAX_ELEMENTS))
        else $error("member count above capacity");

    a_bits_match_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == obs_pkg::ST_IDLE) |-> ($countones(bits_reg) == count_reg))
        else $error("bitmap and order list disagree on member count");

    a_compact_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == obs_pkg::ST_COMPACT) |-> (wr_reg <= rd_reg))
        else $error("compaction write pointer passed read pointer");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (in_req == obs_pkg::REQ_CLEAR)) |=> (count_reg == '0 && bits_reg == '0))
        else $error("clear left members behind");

endmodule

### tb/ordered_bitmap_subset_core_tb.sv
`timescale 1ns / 100ps

module ordered_bitmap_subset_core_tb;

    // Code 7 is unused by the block and must decode as a plain query.
    localparam logic [obs_pkg::REQ_W-1:0] REQ_SPARE = 3'd7;

    localparam int CLK_HALF         = 2;
    localparam int RESET_CYCLES     = 3;
    localparam int IDLE_PERCENT     = 13;
    localparam int PHASE_ITEMS      = 130;
    // Longest walk is a union over 64 indices plus the output register.
    localparam int DRAIN_CYCLES     = 80;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int SHOWN_MISMATCHES = 10;

    logic                         aclk          = 1'b0;
    logic                         aresetn       = 1'b0;
    logic                         cfg_wr_en     = 1'b0;
    logic [obs_pkg::CNT_W-1:0]    cfg_wr_data   = '0;
    logic                         s_valid       = 1'b0;
    logic                         s_ready;
    logic [obs_pkg::REQ_W-1:0]    s_req_type    = '0;
    logic [obs_pkg::IDX_W-1:0]    s_elem_index  = '0;
    logic [obs_pkg::MASK_W-1:0]   s_other_mask  = '0;
    logic                         m_valid;
    logic                         m_ready       = 1'b0;
    logic                         m_in_range;
    logic [obs_pkg::CNT_W-1:0]    m_popped_index;
    logic                         m_member_bit;
    logic [obs_pkg::CNT_W-1:0]    m_member_count;
    logic                         m_empty_flag;
    logic                         m_same_as_mask;
    logic                         m_covers_mask;
    logic                         m_within_mask;

    // Shadow copy of the subset: membership bitmap, arrival order and the
    // universe size as last written.
    logic [obs_pkg::MASK_W-1:0]   set_bits      = '0;
    logic [obs_pkg::IDX_W-1:0]    arrival_order[$];
    logic [obs_pkg::CNT_W-1:0]    universe_reg  = obs_pkg::NUM_ELEM_RESET;

    obs_pkg::result_t             expected_results[$];
    obs_pkg::result_t             got_result;
    obs_pkg::result_t             want_result;
    string                        diff_list;

    bit                           steady          = 1'b0;  // no idling on either side
    int                           items_sent      = 0;
    int                           results_checked = 0;
    int                           mismatches      = 0;
    int                           cfg_writes      = 0;
    int unsigned                  cycles          = 0;

    ordered_bitmap_subset_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_elem_index   (s_elem_index),
        .s_other_mask   (s_other_mask),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_in_range     (m_in_range),
        .m_popped_index (m_popped_index),
        .m_member_bit   (m_member_bit),
        .m_member_count (m_member_count),
        .m_empty_flag   (m_empty_flag),
        .m_same_as_mask (m_same_as_mask),
        .m_covers_mask  (m_covers_mask),
        .m_within_mask  (m_within_mask)
    );

    // Packed order matches result_t.
    assign got_result = {m_in_range, m_popped_index, m_member_bit, m_member_count,
                         m_empty_flag, m_same_as_mask, m_covers_mask, m_within_mask};

    always #(CLK_HALF) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Subset predictor
    // ------------------------------------------------------------------

    // Universe in use: the register value, saturated at the bitmap width.
    function automatic int active_size();
        return (universe_reg > obs_pkg::MAX_ELEMENTS) ? obs_pkg::MAX_ELEMENTS
                                                      : int'(universe_reg);
    endfunction

    function automatic logic [obs_pkg::MASK_W-1:0] active_span();
        logic [obs_pkg::MASK_W-1:0] span;
        span = '0;
        for (int i = 0; i < active_size(); i++) span[i] = 1'b1;
        return span;
    endfunction

    // Append an absent index at the tail of the arrival order.
    function automatic void take_member(input int idx);
        if (set_bits[idx]) return;
        set_bits[idx] = 1'b1;
        arrival_order.insert(arrival_order.size(), obs_pkg::IDX_W'(idx));
    endfunction

    // Drop a present index from wherever it sits in the arrival order.
    function automatic void drop_member(input int idx);
        int p;
        if (!set_bits[idx]) return;
        set_bits[idx] = 1'b0;
        for (p = 0; p < arrival_order.size(); p++) begin
            if (arrival_order[p] == idx) break;
        end
        if (p < arrival_order.size()) arrival_order.delete(p);
    endfunction

    // Apply one request to the shadow subset and return the result it causes.
    function automatic obs_pkg::result_t apply_request(
            input logic [obs_pkg::REQ_W-1:0]  req,
            input logic [obs_pkg::IDX_W-1:0]  idx,
            input logic [obs_pkg::MASK_W-1:0] mask);
        int                         n;
        logic [obs_pkg::MASK_W-1:0] span;
        logic [obs_pkg::MASK_W-1:0] m;
        logic [obs_pkg::MASK_W-1:0] held;
        obs_pkg::result_t           r;
        n    = active_size();
        span = active_span();
        m    = mask & span;        // mask bits outside the universe never count
        r.popped_index = obs_pkg::CNT_W'(n);
        unique case (req)
            obs_pkg::REQ_ADD: begin
                if (idx < n) take_member(idx);
            end
            obs_pkg::REQ_REMOVE: begin
                if (idx < n) drop_member(idx);
            end
            obs_pkg::REQ_POP: begin
                if (arrival_order.size() > 0) begin
                    r.popped_index = obs_pkg::CNT_W'(arrival_order[0]);
                    set_bits[arrival_order[0]] = 1'b0;
                    arrival_order.delete(0);
                end
            end
            obs_pkg::REQ_CLEAR: begin
                set_bits = '0;
                arrival_order.delete();
            end
            obs_pkg::REQ_INTERSECT: begin
                for (int i = 0; i < n; i++) if (!m[i]) drop_member(i);
            end
            obs_pkg::REQ_UNION: begin
                // ascending index order sets the arrival order of new members
                for (int i = 0; i < n; i++) if (m[i]) take_member(i);
            end
            default: begin
            end
        endcase
        held = set_bits & span;
        r.in_range     = (idx < n);
        r.member_bit   = (idx < n) ? set_bits[idx] : 1'b0;
        r.member_count = obs_pkg::CNT_W'(arrival_order.size());
        r.empty_flag   = (arrival_order.size() == 0);
        r.same_as_mask = (held == m);
        r.covers_mask  = ((m & ~held) == '0);
        r.within_mask  = ((held & ~m) == '0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic string show(input obs_pkg::result_t r);
        return $sformatf("rng=%0d pop=%0d bit=%0d cnt=%0d empty=%0d eq=%0d sup=%0d sub=%0d",
                         r.in_range, r.popped_index, r.member_bit, r.member_count,
                         r.empty_flag, r.same_as_mask, r.covers_mask, r.within_mask);
    endfunction

    function automatic string field_diffs(input obs_pkg::result_t want,
                                          input obs_pkg::result_t got);
        string s;
        s = "";
        if (got.in_range     !== want.in_range)     s = {s, " in_range"};
        if (got.popped_index !== want.popped_index) s = {s, " popped_index"};
        if (got.member_bit   !== want.member_bit)   s = {s, " member_bit"};
        if (got.member_count !== want.member_count) s = {s, " member_count"};
        if (got.empty_flag   !== want.empty_flag)   s = {s, " empty_flag"};
        if (got.same_as_mask !== want.same_as_mask) s = {s, " same_as_mask"};
        if (got.covers_mask  !== want.covers_mask)  s = {s, " covers_mask"};
        if (got.within_mask  !== want.within_mask)  s = {s, " within_mask"};
        return s;
    endfunction

    // Count every mismatch, show only the first few.
    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) $display("[%0t] %s", $time, what);
    endfunction

    // Stall the result channel at random and compare each accepted result with
    // the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    note_mismatch({"result with no item outstanding: ", show(got_result)});
                end else begin
                    want_result = expected_results[0];
                    expected_results.delete(0);
                    diff_list   = field_diffs(want_result, got_result);
                    if (diff_list != "") begin
                        note_mismatch($sformatf(
                            "result %0d differs in%s\n    expected %s\n    actual   %s",
                            results_checked, diff_list, show(want_result),
                            show(got_result)));
                    end
                end
            end
        end
    end

    // Bound the run; a hang or a lost result ends here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout at cycle %0d with %0d results outstanding",
                     cycles, expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one item, hold it until accepted, then record what it must cause.
    // Valid is left high on return so a following item can go out back to back.
    task automatic send_item(input logic [obs_pkg::REQ_W-1:0]  req,
                             input logic [obs_pkg::IDX_W-1:0]  idx,
                             input logic [obs_pkg::MASK_W-1:0] mask);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < IDLE_PERCENT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_elem_index <= idx;
        s_other_mask <= mask;
        do @(posedge aclk); while (!s_ready);
        expected_results.insert(expected_results.size(), apply_request(req, idx, mask));
        items_sent++;
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Write num_elements with the block idle; the write also empties the subset.
    task automatic write_universe(input logic [obs_pkg::CNT_W-1:0] value);
        wait_results_done();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        universe_reg  = value;
        set_bits      = '0;
        arrival_order.delete();
        cfg_writes++;
    endtask

    // Masks aimed at the equal, superset and subset tests as well as plain noise.
    function automatic logic [obs_pkg::MASK_W-1:0] pick_mask();
        logic [obs_pkg::MASK_W-1:0] noise;
        noise = {$urandom, $urandom};
        unique case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return set_bits | (noise & ~active_span());  // equal, junk above n
            4:       return set_bits & noise;                      // subset covers it
            5:       return set_bits | noise;                      // subset lies within
            6:       return noise & {$urandom, $urandom} & {$urandom, $urandom};
            default: return noise;
        endcase
    endfunction

    task automatic send_random_item();
        int                        n;
        int                        pick;
        logic [obs_pkg::REQ_W-1:0] req;
        logic [obs_pkg::IDX_W-1:0] idx;
        n    = active_size();
        pick = $urandom_range(99);
        if (pick < 28)      req = obs_pkg::REQ_ADD;
        else if (pick < 46) req = obs_pkg::REQ_REMOVE;
        else if (pick < 56) req = obs_pkg::REQ_POP;
        else if (pick < 59) req = obs_pkg::REQ_CLEAR;
        else if (pick < 69) req = obs_pkg::REQ_INTERSECT;
        else if (pick < 79) req = obs_pkg::REQ_UNION;
        else if (pick < 95) req = obs_pkg::REQ_QUERY;
        else                req = REQ_SPARE;
        // mostly in range, with a share of indices anywhere in the field
        if (n == 0 || $urandom_range(4) == 0) idx = obs_pkg::IDX_W'($urandom_range(63));
        else idx = obs_pkg::IDX_W'($urandom_range(n - 1));
        // aim half the removes at a real member so the list shifts
        if (req == obs_pkg::REQ_REMOVE && arrival_order.size() > 0 && $urandom_range(1))
            idx = arrival_order[$urandom_range(arrival_order.size() - 1)];
        send_item(req, idx, pick_mask());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every request code at the reset universe of 64, including the corner
    // cases: empty pop, repeated add, absent remove, full set.
    task automatic test_basic_requests();
        send_item(obs_pkg::REQ_QUERY,     6'd0,  '0);
        send_item(obs_pkg::REQ_POP,       6'd63, '1);                   // nothing to pop
        send_item(obs_pkg::REQ_ADD,       6'd0,  '0);
        send_item(obs_pkg::REQ_ADD,       6'd63, '0);
        send_item(obs_pkg::REQ_ADD,       6'd0,  '0);                   // already present
        send_item(obs_pkg::REQ_REMOVE,    6'd5,  '0);                   // absent
        send_item(obs_pkg::REQ_UNION,     6'd6,  64'h0000_0000_0000_00F0);
        send_item(obs_pkg::REQ_REMOVE,    6'd5,  64'h8000_0000_0000_00D1); // middle of list
        send_item(obs_pkg::REQ_POP,       6'd0,  '0);
        send_item(obs_pkg::REQ_INTERSECT, 6'd7,  64'h8000_0000_0000_0080);
        send_item(REQ_SPARE,              6'd63, 64'h8000_0000_0000_0080);
        send_item(obs_pkg::REQ_CLEAR,     6'd7,  '1);
        send_item(obs_pkg::REQ_UNION,     6'd42, '1);                   // fill the universe
        send_item(obs_pkg::REQ_INTERSECT, 6'd42, 64'h5555_5555_5555_5555);
    endtask

    // Smallest, empty and oversized universes: out-of-range indices, mask bits
    // above n, and pops on a set that runs dry.
    task automatic test_universe_sizes();
        logic [obs_pkg::CNT_W-1:0] sizes[3];
        sizes = '{7'd1, 7'd0, 7'd127};
        foreach (sizes[k]) begin
            write_universe(sizes[k]);
            send_item(obs_pkg::REQ_UNION, 6'd0,  '1);
            send_item(obs_pkg::REQ_ADD,   6'd63, '0);
            send_item(obs_pkg::REQ_POP,   6'd1,  '1);
            send_item(obs_pkg::REQ_POP,   6'd0,  '1);
        end
    endtask

    // Random requests over a run of universe sizes; one phase pauses until the
    // block has drained before it carries on.
    task automatic test_random_mix();
        logic [obs_pkg::CNT_W-1:0] sizes[9];
        sizes    = '{7'd64, 7'd1, 7'd2, 7'd63, 7'd0, 7'd127, 7'd65, 7'd64, 7'd64};
        sizes[7] = obs_pkg::CNT_W'($urandom_range(3, 62));
        sizes[8] = obs_pkg::CNT_W'($urandom_range(1, 64));
        foreach (sizes[p]) begin
            write_universe(sizes[p]);
            repeat (PHASE_ITEMS / 2) send_random_item();
            if (p == 3) wait_results_done();
            repeat (PHASE_ITEMS - PHASE_ITEMS / 2) send_random_item();
        end
    endtask

    // A long stretch with neither side idling.
    task automatic test_steady_stream();
        write_universe(obs_pkg::NUM_ELEM_RESET);
        steady = 1'b1;
        repeat (PHASE_ITEMS) send_random_item();
        wait_results_done();
        steady = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_basic_requests();
        test_universe_sizes();
        test_random_mix();
        test_steady_stream();

        // Drain, then hold a while to catch any stray result.
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d items (all request codes, masks and indices) over %0d size writes",
                 items_sent, cfg_writes);
        $display("checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
